>>> sv/grid_ray_cast_assert.svh
// Assertion macros for the grid ray caster.
// Used by the top level only; expects clk and rst in scope.
`ifndef GRID_RAY_CAST_ASSERT_SVH
`define GRID_RAY_CAST_ASSERT_SVH

`define GRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define GRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/grc_pkg.sv
// Shared constants, payload types, sequencer states and the arctangent table
// of the grid ray caster. No dependencies.
package grc_pkg;

  localparam int MAP_ROWS    = 16;
  localparam int MAP_COLS    = 32;
  localparam int TILE_PIXELS = 64;
  localparam int FRAC_BITS   = 8;

  localparam int TILE_U     = TILE_PIXELS << FRAC_BITS;
  localparam int TILE_SHIFT = $clog2(TILE_U);
  localparam int MAP_DEPTH  = MAP_ROWS * MAP_COLS;
  localparam int ADDR_W     = $clog2(MAP_DEPTH);
  localparam int ROW_W      = $clog2(MAP_ROWS);
  localparam int COL_W      = $clog2(MAP_COLS);
  localparam int WCNT_W     = $clog2((MAP_ROWS > MAP_COLS ? MAP_ROWS : MAP_COLS) + 3);

  localparam int PX_W    = 19;
  localparam int PY_W    = 18;
  localparam int ANG_W   = 16;
  localparam int Q_W     = 15;
  localparam int TILE_W  = 8;
  localparam int DIST_W  = 20;

  localparam int COORD_W  = 48;
  localparam int MAG_W    = 32;
  localparam int OFS_W    = TILE_SHIFT + 1;
  localparam int NUM_W    = 46;
  localparam int CAP_BIT  = 40;
  localparam int QCAP_W   = CAP_BIT + 1;
  localparam int SQ_W     = 64;
  localparam int ROOT_W   = 32;
  localparam int DMAG_W   = 31;

  localparam int CORDIC_ITERS = 24;
  localparam int CORDIC_CNT_W = 5;
  localparam int CORDIC_GAIN  = 652032874;
  localparam int DIV_CNT_W    = $clog2(NUM_W);
  localparam int SQRT_ITERS   = 32;
  localparam int SQRT_CNT_W   = 5;

  localparam logic [ANG_W-1:0] ANG_QUARTER = 16'd16384;
  localparam logic [ANG_W-1:0] ANG_HALF    = 16'd32768;
  localparam logic [ANG_W-1:0] ANG_3Q      = 16'd49152;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y = 2'd1;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CAST  = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [3:0]       tile_row;
    logic [4:0]       tile_col;
    logic [TILE_W-1:0] tile_value;
    logic [ANG_W-1:0] ray_angle;
  } req_t;

  typedef struct packed {
    logic              hit_found;
    logic              hit_vertical;
    logic [PX_W-1:0]   hit_x;
    logic [PY_W-1:0]   hit_y;
    logic [TILE_W-1:0] hit_content;
    logic [DIST_W-1:0] hit_distance;
    logic [ANG_W-1:0]  angle_out;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CORDIC, ST_FAM, ST_MUL, ST_DIV_OFS, ST_DIV_STEP,
    ST_WALK_CHK, ST_WALK_TST, ST_DSQ_X, ST_DSQ_Y, ST_DSQ_SUM,
    ST_PICK, ST_SQRT, ST_OUT
  } cast_state_t;

  function automatic logic [31:0] atan_turn(input logic [CORDIC_CNT_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/grc_map.sv
// Tile map RAM with a clearing sweep after reset.
// Depends on grc_pkg for map depth and address width.
module grc_map (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [grc_pkg::ADDR_W-1:0] wr_addr,
  input  logic [grc_pkg::TILE_W-1:0] wr_data,
  input  logic [grc_pkg::ADDR_W-1:0] rd_addr,
  output logic [grc_pkg::TILE_W-1:0] rd_data,
  output logic                       clearing
);
  import grc_pkg::*;

  logic [TILE_W-1:0] mem [MAP_DEPTH];
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(MAP_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/grc_cordic.sv
// Iterative CORDIC giving |cos| and |sin| of a first-quadrant angle.
// Depends on grc_pkg for the arctangent table and widths.
module grc_cordic (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [grc_pkg::Q_W-1:0]   q,
  output logic                      busy,
  output logic                      done,
  output logic [grc_pkg::MAG_W-1:0] cos_mag,
  output logic [grc_pkg::MAG_W-1:0] sin_mag
);
  import grc_pkg::*;

  localparam int XW = MAG_W + 2;

  logic signed [XW-1:0] x, y, z, xs, ys, at;
  logic [CORDIC_CNT_W-1:0] cnt;

  assign xs = x >>> cnt;
  assign ys = y >>> cnt;
  assign at = XW'(atan_turn(cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CORDIC_CNT_W'(CORDIC_ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      x <= XW'(CORDIC_GAIN);
      y <= '0;
      z <= XW'(q) <<< 16;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

  assign cos_mag = x[XW-1] ? '0 : x[MAG_W-1:0];
  assign sin_mag = y[XW-1] ? '0 : y[MAG_W-1:0];

endmodule

>>> sv/grc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on grc_pkg for operand widths.
module grc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [grc_pkg::NUM_W-1:0] num,
  input  logic [grc_pkg::MAG_W-1:0] den,
  output logic                      busy,
  output logic                      done,
  output logic [grc_pkg::NUM_W-1:0] quot
);
  import grc_pkg::*;

  logic [MAG_W-1:0]   rem, dv;
  logic [MAG_W:0]     trial;
  logic               fits;
  logic [DIV_CNT_W-1:0] cnt;

  assign trial = {rem, quot[NUM_W-1]};
  assign fits  = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == DIV_CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem  <= '0;
      quot <= num;
      dv   <= den;
    end else if (busy) begin
      rem  <= fits ? MAG_W'(trial - {1'b0, dv}) : trial[MAG_W-1:0];
      quot <= {quot[NUM_W-2:0], fits};
    end
  end

endmodule

>>> sv/grc_sqrt.sv
// Bit-pair integer square root, one root bit per cycle.
// Depends on grc_pkg for operand widths.
module grc_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [grc_pkg::SQ_W-1:0]   n,
  output logic                       busy,
  output logic                       done,
  output logic [grc_pkg::ROOT_W-1:0] root
);
  import grc_pkg::*;

  logic [SQ_W-1:0] rem, r, bitv, sum;
  logic            ge;
  logic [SQRT_CNT_W-1:0] cnt;

  assign sum  = r + bitv;
  assign ge   = rem >= sum;
  assign root = r[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == SQRT_CNT_W'(SQRT_ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem  <= n;
      r    <= '0;
      bitv <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy) begin
      rem  <= ge ? rem - sum : rem;
      r    <= ge ? (r >> 1) + bitv : r >> 1;
      bitv <= bitv >> 2;
    end
  end

endmodule

>>> sv/grid_ray_cast.sv
// Grid ray caster top level: sequencer, shared multiplier, walk datapath.
// Depends on grc_pkg, grc_map, grc_cordic, grc_div, grc_sqrt and the
// assertion header grid_ray_cast_assert.svh.
//
// Requests arrive on req (req_valid/req_stall). A request with kind 0 writes
// one map tile and is done in the cycle it is taken; it gives no result. A
// request with kind 1 casts a ray and gives exactly one result on res
// (res_valid/res_stall). Player position is written on the cfg port
// (cfg_valid/cfg_ready, always ready); the user must write it only while
// the block is idle, which the block itself does not enforce. A cast runs
// the CORDIC, then for each crossing family that is not skipped two
// divisions on the shared divider and a walk over the grid crossings (one
// map RAM read each), then a square root when a wall was hit. The block
// takes one request at a time; req_stall is high for the whole cast. The
// result waits in an output register, so the next request is taken while
// res_stall holds the previous result; a cast that finishes meanwhile
// waits until the register frees.
// After reset the map RAM is cleared at one tile per cycle, all 512 tiles,
// with req_stall high; configuration writes are taken during that sweep.
module grid_ray_cast (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  grc_pkg::req_t                 req,
  output logic                          res_valid,
  input  logic                          res_stall,
  output grc_pkg::res_t                 res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [grc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [grc_pkg::PX_W-1:0]      cfg_data
);
  import grc_pkg::*;

  localparam logic signed [COORD_W-1:0] MAP_W     = COORD_W'(MAP_COLS * TILE_U);
  localparam logic signed [COORD_W-1:0] MAP_H     = COORD_W'(MAP_ROWS * TILE_U);
  localparam logic signed [COORD_W-1:0] TILE_STEP = COORD_W'(TILE_U);
  localparam logic [COORD_W-1:0]        TILE_MASK = ~(COORD_W'(TILE_U) - 1'b1);
  localparam logic [QCAP_W-1:0]         STEP_CAP  = QCAP_W'(1) << CAP_BIT;
  localparam logic [ROOT_W-1:0]         DIST_MAX  = ROOT_W'((1 << DIST_W) - 1);

  cast_state_t state, state_next;

  logic              req_acc, clearing, fam_end, res_load;
  logic [PX_W-1:0]   px;
  logic [PY_W-1:0]   py;
  logic [ANG_W-1:0]  ang, q_in;
  logic [Q_W-1:0]    q;
  logic              down, right, dir;

  logic              cordic_start, cordic_busy, cordic_done;
  logic [MAG_W-1:0]  cm, sm, num_sel, den_sel;
  logic              div_start, div_busy, div_done;
  logic [NUM_W-1:0]  div_num, div_quot;
  logic              sqrt_start, sqrt_busy, sqrt_done;
  logic [ROOT_W-1:0] root;

  logic [MAG_W-1:0]  mul_a, mul_b;
  logic [SQ_W-1:0]   mul_p, prod, sq_acc;

  logic signed [COORD_W-1:0] px_c, py_c, base_x, base_y, dx0, dy0, qc, signed_q;
  logic signed [COORD_W-1:0] wx, wy, sx, sy, tx, ty, ax, ay;
  logic [COORD_W-1:0]        abs_dx0, abs_dy0, absx, absy;
  logic [QCAP_W-1:0]         q_cap;
  logic [OFS_W-1:0]          mag;
  logic                      skip, neg_sel, w_out, t_in, capped, hit;
  logic [WCNT_W-1:0]         wcnt, wcnt_inc, w_cap;
  logic [ROW_W-1:0]          t_row;
  logic [COL_W-1:0]          t_col;
  logic [ADDR_W-1:0]         rd_addr, wr_addr;
  logic [TILE_W-1:0]         rd_data;
  logic                      wr_en;

  logic [1:0]        h_found;
  logic [PX_W-1:0]   h_x [2];
  logic [PY_W-1:0]   h_y [2];
  logic [TILE_W-1:0] h_c [2];
  logic [SQ_W-1:0]   h_d2 [2];
  logic [DMAG_W-1:0] dmx, dmy;
  logic              dbig, pick_vert, pick_any;
  logic              r_found, r_vert;
  logic [PX_W-1:0]   r_x;
  logic [PY_W-1:0]   r_y;
  logic [TILE_W-1:0] r_c;

  assign req_stall = clearing || (state != ST_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign cfg_ready = 1'b1;

  assign wr_addr = ADDR_W'(ADDR_W'(req.tile_row) * ADDR_W'(MAP_COLS)) + ADDR_W'(req.tile_col);
  assign wr_en   = req_acc && (req.kind == KIND_WRITE) &&
                   (int'(req.tile_row) < MAP_ROWS) && (int'(req.tile_col) < MAP_COLS);

  assign q_in = (ANG_W'(req.ray_angle[Q_W-1:0]) > ANG_QUARTER) ?
                ANG_HALF - ANG_W'(req.ray_angle[Q_W-1:0]) : ANG_W'(req.ray_angle[Q_W-1:0]);

  grc_map u_map (
    .clk, .rst, .wr_en, .wr_addr, .wr_data(req.tile_value),
    .rd_addr, .rd_data, .clearing
  );

  grc_cordic u_cordic (
    .clk, .rst, .start(cordic_start), .q(q_in[Q_W-1:0]),
    .busy(cordic_busy), .done(cordic_done), .cos_mag(cm), .sin_mag(sm)
  );

  grc_div u_div (
    .clk, .rst, .start(div_start), .num(div_num), .den(den_sel),
    .busy(div_busy), .done(div_done), .quot(div_quot)
  );

  grc_sqrt u_sqrt (
    .clk, .rst, .start(sqrt_start), .n(pick_vert ? h_d2[1] : h_d2[0]),
    .busy(sqrt_busy), .done(sqrt_done), .root
  );

  assign num_sel = dir ? sm : cm;
  assign den_sel = dir ? cm : sm;
  assign skip    = dir ? ((q == Q_W'(ANG_QUARTER)) || (cm == '0)) : ((q == '0) || (sm == '0));
  assign neg_sel = dir ? !down : !right;

  assign px_c    = COORD_W'(px);
  assign py_c    = COORD_W'(py);
  assign base_y  = (py_c & TILE_MASK) + (down ? TILE_STEP : '0);
  assign base_x  = (px_c & TILE_MASK) + (right ? TILE_STEP : '0);
  assign dy0     = base_y - py_c;
  assign dx0     = base_x - px_c;
  assign abs_dy0 = dy0[COORD_W-1] ? -dy0 : dy0;
  assign abs_dx0 = dx0[COORD_W-1] ? -dx0 : dx0;

  assign q_cap    = (div_quot > NUM_W'(STEP_CAP)) ? STEP_CAP : div_quot[QCAP_W-1:0];
  assign qc       = COORD_W'(q_cap);
  assign signed_q = neg_sel ? -qc : qc;

  assign w_out = (wx < 0) || (wy < 0) || (wx > MAP_W) || (wy > MAP_H);
  assign tx    = wx - ((dir && !right) ? COORD_W'(1) : COORD_W'(0));
  assign ty    = wy - ((!dir && !down) ? COORD_W'(1) : COORD_W'(0));
  assign t_in  = (tx >= 0) && (ty >= 0) && (tx < MAP_W) && (ty < MAP_H);
  assign t_row = ty[TILE_SHIFT+ROW_W-1:TILE_SHIFT];
  assign t_col = tx[TILE_SHIFT+COL_W-1:TILE_SHIFT];
  assign rd_addr = ADDR_W'(ADDR_W'(t_row) * ADDR_W'(MAP_COLS)) + ADDR_W'(t_col);

  assign wcnt_inc = wcnt + 1'b1;
  assign w_cap    = dir ? WCNT_W'(MAP_COLS + 2) : WCNT_W'(MAP_ROWS + 2);
  assign capped   = wcnt_inc >= w_cap;
  assign hit      = rd_data != '0;

  assign ax   = wx - px_c;
  assign ay   = wy - py_c;
  assign absx = ax[COORD_W-1] ? -ax : ax;
  assign absy = ay[COORD_W-1] ? -ay : ay;

  assign pick_any  = h_found[0] || h_found[1];
  assign pick_vert = h_found[1] && (!h_found[0] || (h_d2[1] < h_d2[0]));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MUL: begin
        mul_a = MAG_W'(mag);
        mul_b = num_sel;
      end
      ST_DSQ_X: begin
        mul_a = MAG_W'(dmx);
        mul_b = MAG_W'(dmx);
      end
      ST_DSQ_Y: begin
        mul_a = MAG_W'(dmy);
        mul_b = MAG_W'(dmy);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = SQ_W'(mul_a) * SQ_W'(mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cordic_start = 1'b0;
    div_start    = 1'b0;
    div_num      = '0;
    sqrt_start   = 1'b0;
    fam_end      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_acc && (req.kind == KIND_CAST)) begin
          cordic_start = 1'b1;
          state_next   = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        if (cordic_done) state_next = ST_FAM;
      end
      ST_FAM: begin
        if (skip) fam_end = 1'b1;
        else state_next = ST_MUL;
      end
      ST_MUL: begin
        div_start  = 1'b1;
        div_num    = mul_p[NUM_W-1:0];
        state_next = ST_DIV_OFS;
      end
      ST_DIV_OFS: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_num    = NUM_W'(num_sel) << TILE_SHIFT;
          state_next = ST_DIV_STEP;
        end
      end
      ST_DIV_STEP: begin
        if (div_done) state_next = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (w_out) fam_end = 1'b1;
        else if (t_in) state_next = ST_WALK_TST;
        else if (capped) fam_end = 1'b1;
      end
      ST_WALK_TST: begin
        if (hit) state_next = ST_DSQ_X;
        else if (capped) fam_end = 1'b1;
        else state_next = ST_WALK_CHK;
      end
      ST_DSQ_X:   state_next = ST_DSQ_Y;
      ST_DSQ_Y:   state_next = ST_DSQ_SUM;
      ST_DSQ_SUM: fam_end = 1'b1;
      ST_PICK: begin
        if (pick_any) begin
          sqrt_start = 1'b1;
          state_next = ST_SQRT;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_SQRT: begin
        if (sqrt_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!res_valid || !res_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    if (fam_end) state_next = dir ? ST_PICK : ST_FAM;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      px <= '0;
      py <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_PLAYER_X) px <= cfg_data;
      else if (cfg_index == CFG_PLAYER_Y) py <= cfg_data[PY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req_acc && (req.kind == KIND_CAST)) begin
          ang     <= req.ray_angle;
          q       <= q_in[Q_W-1:0];
          down    <= (req.ray_angle != '0) && (req.ray_angle < ANG_HALF);
          right   <= (req.ray_angle < ANG_QUARTER) || (req.ray_angle > ANG_3Q);
          dir     <= 1'b0;
          h_found <= '0;
        end
      end
      ST_FAM: begin
        if (!skip) begin
          if (!dir) begin
            wy  <= base_y;
            mag <= abs_dy0[OFS_W-1:0];
          end else begin
            wx  <= base_x;
            mag <= abs_dx0[OFS_W-1:0];
          end
        end
      end
      ST_DIV_OFS: begin
        if (div_done) begin
          if (!dir) wx <= px_c + signed_q;
          else wy <= py_c + signed_q;
        end
      end
      ST_DIV_STEP: begin
        if (div_done) begin
          wcnt <= '0;
          if (!dir) begin
            sx <= signed_q;
            sy <= down ? TILE_STEP : -TILE_STEP;
          end else begin
            sx <= right ? TILE_STEP : -TILE_STEP;
            sy <= signed_q;
          end
        end
      end
      ST_WALK_CHK: begin
        if (!w_out && !t_in) begin
          wx   <= wx + sx;
          wy   <= wy + sy;
          wcnt <= wcnt_inc;
        end
      end
      ST_WALK_TST: begin
        if (hit) begin
          h_found[dir] <= 1'b1;
          h_x[dir]     <= wx[PX_W-1:0];
          h_y[dir]     <= wy[PY_W-1:0];
          h_c[dir]     <= rd_data;
          dmx          <= absx[DMAG_W-1:0];
          dmy          <= absy[DMAG_W-1:0];
          dbig         <= (|absx[COORD_W-1:DMAG_W]) || (|absy[COORD_W-1:DMAG_W]);
        end else begin
          wx   <= wx + sx;
          wy   <= wy + sy;
          wcnt <= wcnt_inc;
        end
      end
      ST_DSQ_X: prod <= mul_p;
      ST_DSQ_Y: begin
        sq_acc <= prod;
        prod   <= mul_p;
      end
      ST_DSQ_SUM: h_d2[dir] <= dbig ? '1 : sq_acc + prod;
      ST_PICK: begin
        r_found <= pick_any;
        r_vert  <= pick_vert;
        r_x     <= pick_vert ? h_x[1] : h_x[0];
        r_y     <= pick_vert ? h_y[1] : h_y[0];
        r_c     <= pick_vert ? h_c[1] : h_c[0];
      end
      default: begin
      end
    endcase
    if (fam_end && !dir) dir <= 1'b1;
  end

  assign res_load = (state == ST_OUT) && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.hit_found    <= r_found;
      res.hit_vertical <= r_found && r_vert;
      res.hit_x        <= r_found ? r_x : '0;
      res.hit_y        <= r_found ? r_y : '0;
      res.hit_content  <= r_found ? r_c : '0;
      res.hit_distance <= (r_found && (root <= DIST_MAX)) ? root[DIST_W-1:0] : '1;
      res.angle_out    <= ang;
    end
  end

`include "grid_ray_cast_assert.svh"

  `GRC_ASSERT_NOW(a_clear_idle, clearing, state == ST_IDLE, "cast running during map clear")
  `GRC_ASSERT_NOW(a_cordic_live, state == ST_CORDIC, cordic_busy || cordic_done, "cordic stalled")
  `GRC_ASSERT_NOW(a_div_live, (state == ST_DIV_OFS) || (state == ST_DIV_STEP), div_busy || div_done, "divider stalled")
  `GRC_ASSERT_NOW(a_sqrt_live, state == ST_SQRT, sqrt_busy || sqrt_done, "square root stalled")

endmodule

>>> dv/grid_ray_cast_test.sv
// Self-checking testbench for grid_ray_cast: random tile maps, player
// positions and ray casts, checked against an in-bench DDA ray predictor.
// Depends on grc_pkg and the grid_ray_cast RTL.
module grid_ray_cast_test;
  import grc_pkg::*;

  localparam longint TU = TILE_U;
  localparam longint MW = longint'(MAP_COLS) * TU;
  localparam longint MH = longint'(MAP_ROWS) * TU;
  localparam longint STEP_CAP = 64'd1 << 40;
  localparam longint LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PX_W-1:0] cfg_data = '0;

  grid_ray_cast dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [TILE_W-1:0] tile_map [MAP_DEPTH];
  logic [PX_W-1:0] pos_x;
  logic [PY_W-1:0] pos_y;
  res_t hits_due [$];
  int errors = 0;
  longint cycles = 0;
  bit quiet = 0;
  int stall_left = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 15);
    if (quiet || r < 8) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint ratio(longint unsigned mag, longint unsigned num,
                                   longint unsigned den, bit neg);
    longint unsigned r;
    r = (mag * num) / den;
    if (r > STEP_CAP) r = STEP_CAP;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic bit trace(longint x, longint y, longint sx, longint sy,
                               longint cx, longint cy, int cap, output longint hx,
                               output longint hy, output logic [TILE_W-1:0] hc);
    longint tx, ty;
    logic [TILE_W-1:0] v;
    hx = 0; hy = 0; hc = 0;
    for (int n = 0; n < cap; n++) begin
      if (x < 0 || y < 0 || x > MW || y > MH) break;
      tx = x + cx;
      ty = y + cy;
      if (tx >= 0 && ty >= 0 && tx < MW && ty < MH) begin
        v = tile_map[(ty / TU) * MAP_COLS + (tx / TU)];
        if (v != 0) begin
          hx = x; hy = y; hc = v;
          return 1;
        end
      end
      x += sx;
      y += sy;
    end
    return 0;
  endfunction

  function automatic longint unsigned range_sq(longint hx, longint hy);
    longint a, b;
    longint unsigned dx, dy;
    a = hx - longint'(pos_x);
    b = hy - longint'(pos_y);
    dx = a < 0 ? -a : a;
    dy = b < 0 ? -b : b;
    if (dx >= (64'd1 << 31) || dy >= (64'd1 << 31)) return '1;
    return dx * dx + dy * dy;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic res_t cast_ray(logic [ANG_W-1:0] a);
    res_t o;
    bit down, right, fh, fv, vert;
    int unsigned q;
    longint x, y, z, xs, ys, px, py, y0, x0, d, stp;
    longint hxh, hyh, hxv, hyv;
    longint unsigned cm, sm, d2h, d2v, d2, r;
    logic [TILE_W-1:0] hch, hcv;
    px = pos_x;
    py = pos_y;
    fh = 0; fv = 0;
    d2h = '1; d2v = '1;
    hxh = 0; hyh = 0; hxv = 0; hyv = 0; hch = 0; hcv = 0;
    down = a > 0 && a < ANG_HALF;
    right = a < ANG_QUARTER || a > ANG_3Q;
    q = a & 16'h7FFF;
    if (q > 16384) q = 32768 - q;
    x = CORDIC_GAIN; y = 0; z = longint'(q) << 16;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      xs = asr(x, i);
      ys = asr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_turn(CORDIC_CNT_W'(i));
      end else begin
        x += ys; y -= xs; z += atan_turn(CORDIC_CNT_W'(i));
      end
    end
    cm = x < 0 ? 0 : x;
    sm = y < 0 ? 0 : y;
    if (q != 0 && sm != 0) begin
      y0 = (py / TU) * TU + (down ? TU : 0);
      d = y0 - py;
      x0 = px + ratio(d < 0 ? -d : d, cm, sm, !right);
      stp = ratio(TU, cm, sm, !right);
      fh = trace(x0, y0, stp, down ? TU : -TU, 0, down ? 0 : -1, MAP_ROWS + 2,
                 hxh, hyh, hch);
      if (fh) d2h = range_sq(hxh, hyh);
    end
    if (q != 16384 && cm != 0) begin
      x0 = (px / TU) * TU + (right ? TU : 0);
      d = x0 - px;
      y0 = py + ratio(d < 0 ? -d : d, sm, cm, !down);
      stp = ratio(TU, sm, cm, !down);
      fv = trace(x0, y0, right ? TU : -TU, stp, right ? -0 : -1, 0, MAP_COLS + 2,
                 hxv, hyv, hcv);
      if (!right) fv = trace(x0, y0, -TU, stp, -1, 0, MAP_COLS + 2, hxv, hyv, hcv);
      if (fv) d2v = range_sq(hxv, hyv);
    end
    vert = fv && (!fh || d2v < d2h);
    o = '0;
    if (vert || fh) begin
      d2 = vert ? d2v : d2h;
      r = int_sqrt(d2);
      if (r > 64'hFFFFF) r = 64'hFFFFF;
      o.hit_found = 1'b1;
      o.hit_vertical = vert;
      o.hit_x = vert ? hxv[PX_W-1:0] : hxh[PX_W-1:0];
      o.hit_y = vert ? hyv[PY_W-1:0] : hyh[PY_W-1:0];
      o.hit_content = vert ? hcv : hch;
      o.hit_distance = r[DIST_W-1:0];
    end else begin
      o.hit_distance = '1;
    end
    o.angle_out = a;
    return o;
  endfunction

  task automatic send_request(req_t r);
    int g;
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    if (r.kind == KIND_WRITE) tile_map[{r.tile_row, r.tile_col}] = r.tile_value;
    else hits_due.push_back(cast_ray(r.ray_angle));
    g = pick_gap();
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PX_W-1:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_PLAYER_X) pos_x = v;
    else if (idx == CFG_PLAYER_Y) pos_y = v[PY_W-1:0];
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (hits_due.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic req_t tile_req(int row, int col, int v);
    req_t r;
    r = '0;
    r.kind = KIND_WRITE;
    r.tile_row = ROW_W'(row);
    r.tile_col = COL_W'(col);
    r.tile_value = TILE_W'(v);
    r.ray_angle = ANG_W'($urandom);
    return r;
  endfunction

  function automatic req_t cast_req(logic [ANG_W-1:0] a);
    req_t r;
    r = '0;
    r.kind = KIND_CAST;
    r.tile_row = ROW_W'($urandom);
    r.tile_col = COL_W'($urandom);
    r.tile_value = TILE_W'($urandom);
    r.ray_angle = a;
    return r;
  endfunction

  task automatic test_empty_and_axes();
    logic [ANG_W-1:0] angs [8] = '{16'd0, ANG_QUARTER, ANG_HALF, ANG_3Q,
                                   16'd1, 16'hFFFF, 16'd8192, 16'd40000};
    write_reg(CFG_PLAYER_X, 19'd100000);
    write_reg(CFG_PLAYER_Y, 19'd70000);
    write_reg(2'd2, '1);
    write_reg(2'd3, 19'd12345);
    send_request(cast_req(16'd5000));
    send_request(tile_req(0, 0, 255));
    send_request(tile_req(15, 31, 1));
    send_request(tile_req(4, 3, 8'h5A));
    send_request(tile_req(4, 9, 8'hA5));
    send_request(tile_req(1, 6, 7));
    send_request(tile_req(9, 6, 200));
    foreach (angs[i]) send_request(cast_req(angs[i]));
    settle();
    write_reg(CFG_PLAYER_X, '1);
    write_reg(CFG_PLAYER_Y, '1);
    foreach (angs[i]) send_request(cast_req(angs[i]));
    settle();
    write_reg(CFG_PLAYER_X, '0);
    write_reg(CFG_PLAYER_Y, '0);
    send_request(cast_req(16'd8192));
    send_request(cast_req(16'd1));
    send_request(cast_req(16'd16383));
    settle();
  endtask

  task automatic test_random_maps(int total);
    int sent, walls, casts, r;
    sent = 0;
    while (sent < total) begin
      quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      write_reg(CFG_PLAYER_X, r == 0 ? '1 : r == 1 ? '0 : PX_W'($urandom));
      write_reg(CFG_PLAYER_Y, r == 0 ? '1 : r == 2 ? '0 : PX_W'(PY_W'($urandom)));
      if ($urandom_range(0, 7) == 0)
        write_reg(CFG_IDX_W'($urandom_range(2, 3)), PX_W'($urandom));
      walls = $urandom_range(2, 40);
      for (int i = 0; i < walls; i++) begin
        send_request(tile_req($urandom_range(0, 15), $urandom_range(0, 31),
                              $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 255)));
        sent++;
      end
      casts = $urandom_range(10, 40);
      for (int i = 0; i < casts; i++) begin
        r = $urandom_range(0, 9);
        if (r == 0)
          send_request(cast_req(ANG_W'(ANG_QUARTER * $urandom_range(0, 3))));
        else if (r == 1)
          send_request(cast_req(ANG_W'(ANG_QUARTER * $urandom_range(0, 3) +
                                       $urandom_range(0, 4) - 2)));
        else if (r == 2)
          send_request(tile_req($urandom, $urandom, $urandom));
        else
          send_request(cast_req(ANG_W'($urandom)));
        sent++;
      end
      settle();
    end
    quiet = 0;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        res_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : 0;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (!rst && res_valid && !res_stall) begin
      if (hits_due.size() == 0) begin
        $display("%0t unexpected result: actual %p", $time, res);
        errors++;
      end else begin
        e = hits_due.pop_front();
        check_field("hit_found", e.hit_found, res.hit_found);
        check_field("hit_vertical", e.hit_vertical, res.hit_vertical);
        check_field("hit_x", e.hit_x, res.hit_x);
        check_field("hit_y", e.hit_y, res.hit_y);
        check_field("hit_content", e.hit_content, res.hit_content);
        check_field("hit_distance", e.hit_distance, res.hit_distance);
        check_field("angle_out", e.angle_out, res.angle_out);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    foreach (tile_map[i]) tile_map[i] = '0;
    pos_x = '0;
    pos_y = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_axes();
    test_random_maps(1430);
    settle();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+sv
sv/grc_pkg.sv
sv/grc_map.sv
sv/grc_cordic.sv
sv/grc_div.sv
sv/grc_sqrt.sv
sv/grid_ray_cast.sv
dv/grid_ray_cast_test.sv
